/* sv/idle_slide_fade_animator_defines.svh */
// Assertion helpers for the animator's checks.
`ifndef IDLE_SLIDE_FADE_ANIMATOR_DEFINES_SVH
`define IDLE_SLIDE_FADE_ANIMATOR_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define ISFA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("isfa: same-cycle implication violated");

// Next-cycle implication, checked out of reset.
`define ISFA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("isfa: next-cycle implication violated");

`endif

/* sv/isfa_pkg.sv */
package isfa_pkg;

    // Fraction bits of offset, alpha and velocity (Q23.8 by default).
    localparam int FRAC_BITS_DEF = 8;

    // Shared multiplier: signed A operand times unsigned B operand.
    localparam int MUL_A_W = 34;
    localparam int MUL_B_W = 17;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W + 1;

    // Tick time in Q0.16 seconds after limiting.
    localparam int DT_W = 13;
    localparam logic [15:0]     DT_LIMIT = 16'd6554;
    localparam logic [DT_W-1:0] DT_SUBST = 13'd3277;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_HIDE_DELAY  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POS_SPEED   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POS_ACCEL   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_SPEED = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_ACCEL = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_H    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MOVE_THR    = 3'd6;

    typedef logic signed [MUL_P_W-1:0] t_prod;

    typedef struct packed {
        logic                      start;
        logic signed [MUL_A_W-1:0] a;
        logic        [MUL_B_W-1:0] b;
    } t_mul_req;

endpackage

/* sv/isfa_mul.sv */
module isfa_mul
    import isfa_pkg::*;
(
    input  logic     i_clk,
    input  t_mul_req i_req,
    output t_prod    o_prod
);

    t_prod r_prod;

    // Capture a product on request; hold it otherwise.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_prod <= i_req.a * $signed({1'b0, i_req.b});
        end
    end

    assign o_prod = r_prod;

endmodule

/* sv/idle_slide_fade_animator.sv */
// Channel   Direction  Handshake                  Payload
// cfg       in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
// in        in         i_in_valid  / o_in_ready   time, cursor x/y, on_desktop, elapsed
// out       out        o_out_valid / i_out_ready  offset, alpha, change flags, hidden, settled
//
// A small sequencer steps one shared 34x17 multiplier; a new request is accepted only
// once the previous tick has left its final step. Each motion (offset, then alpha)
// either snaps in its evaluate step or spends two or three more steps on two or
// three products. Reset is synchronous, active low: it restores register defaults
// and state. A finished result sits in the output register; the next request may be
// accepted meanwhile, and the final step holds until the old result is taken.
`include "idle_slide_fade_animator_defines.svh"

module idle_slide_fade_animator
    import isfa_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data,

    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [31:0]          i_time_ms,
    input  logic signed [15:0]   i_cursor_x,
    input  logic signed [15:0]   i_cursor_y,
    input  logic                 i_on_desktop,
    input  logic [15:0]          i_elapsed_q16,

    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [12:0]          o_render_offset,
    output logic [7:0]           o_render_alpha,
    output logic                 o_offset_changed,
    output logic                 o_alpha_changed,
    output logic                 o_hidden,
    output logic                 o_settled
);

    // Fixed-point constants follow the fraction width.
    localparam int ONE    = 1 << FRAC_BITS;
    localparam int HALF   = 1 << (FRAC_BITS - 1);
    localparam int TENTH  = (ONE + 5) / 10;
    localparam int ACC_SH = 16 - FRAC_BITS;
    localparam int DT_SH  = 16;

    localparam logic signed [31:0]      ALPHA_FULL   = 32'(255 * ONE);
    localparam logic signed [MUL_A_W-1:0] OFS_MIN_SPD = MUL_A_W'(-20 * ONE);
    localparam logic signed [MUL_A_W-1:0] ALF_MIN_SPD = MUL_A_W'(10 * ONE);
    localparam t_prod SAT_HI = t_prod'(64'sd2147483647);
    localparam t_prod SAT_LO = t_prod'(-64'sd2147483648);

    // Sequencer codes.
    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_SETTLE = 5'd1;
    localparam logic [4:0] S_OFS    = 5'd2;
    localparam logic [4:0] S_OUP1   = 5'd3;
    localparam logic [4:0] S_OUP2   = 5'd4;
    localparam logic [4:0] S_OUP3   = 5'd5;
    localparam logic [4:0] S_ODN1   = 5'd6;
    localparam logic [4:0] S_ODN2   = 5'd7;
    localparam logic [4:0] S_ODN3   = 5'd8;
    localparam logic [4:0] S_ALF    = 5'd9;
    localparam logic [4:0] S_AUP1   = 5'd10;
    localparam logic [4:0] S_AUP2   = 5'd11;
    localparam logic [4:0] S_AUP3   = 5'd12;
    localparam logic [4:0] S_ADN1   = 5'd13;
    localparam logic [4:0] S_ADN2   = 5'd14;
    localparam logic [4:0] S_ADN3   = 5'd15;
    localparam logic [4:0] S_OUT    = 5'd16;

    function automatic logic signed [31:0] sat32(input t_prod v);
        logic signed [31:0] r;
        if (v > SAT_HI) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < SAT_LO) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic [32:0] abs33(input logic signed [32:0] v);
        return v[32] ? 33'(-v) : 33'(v);
    endfunction

    // Whole units of a fixed-point value, limited to 0..top.
    function automatic logic [12:0] whole_lim(input logic signed [31:0] v,
                                              input logic [12:0] top);
        logic signed [31:0] w;
        logic [12:0]        r;
        w = v >>> FRAC_BITS;
        if (v < 0) begin
            r = '0;
        end else if (w > $signed({19'd0, top})) begin
            r = top;
        end else begin
            r = w[12:0];
        end
        return r;
    endfunction

    // Configuration registers.
    logic [31:0] r_hide_delay;
    logic [7:0]  r_pos_speed;
    logic [15:0] r_pos_accel;
    logic [7:0]  r_alpha_speed;
    logic [15:0] r_alpha_accel;
    logic [12:0] r_screen_h;
    logic [7:0]  r_move_thr;

    // Motion state.
    logic [4:0]         r_state, n_state;
    logic signed [31:0] r_ofs_now, n_ofs_now;
    logic signed [31:0] r_ofs_goal, n_ofs_goal;
    logic signed [31:0] r_ofs_vel, n_ofs_vel;
    logic signed [31:0] r_alf_now, n_alf_now;
    logic signed [31:0] r_alf_goal, n_alf_goal;
    logic signed [31:0] r_alf_vel, n_alf_vel;
    logic [12:0]        r_last_ofs, n_last_ofs;
    logic [7:0]         r_last_alf, n_last_alf;
    logic signed [15:0] r_prev_x, n_prev_x;
    logic signed [15:0] r_prev_y, n_prev_y;
    logic [31:0]        r_active_since, n_active_since;
    logic               r_hidden, n_hidden;
    logic [DT_W-1:0]    r_dt, n_dt;
    logic               r_settled, n_settled;
    logic               r_clamp, n_clamp;

    // Output register.
    logic        r_out_valid, n_out_valid;
    logic [12:0] r_out_ofs, n_out_ofs;
    logic [7:0]  r_out_alf, n_out_alf;
    logic        r_out_ofs_chg, n_out_ofs_chg;
    logic        r_out_alf_chg, n_out_alf_chg;
    logic        r_out_hidden, n_out_hidden;
    logic        r_out_settled, n_out_settled;

    t_mul_req mul_req;
    t_prod    prod;

    isfa_mul u_mul (
        .i_clk  (i_clk),
        .i_req  (mul_req),
        .o_prod (prod)
    );

    // Distances and bands, read by several steps.
    logic signed [32:0] ofs_diff, alf_diff;
    logic [32:0]        ofs_diff_abs, alf_diff_abs, ofs_vel_abs, alf_vel_abs;
    logic               ofs_active, alf_active;

    assign ofs_diff     = {r_ofs_goal[31], r_ofs_goal} - {r_ofs_now[31], r_ofs_now};
    assign alf_diff     = {r_alf_goal[31], r_alf_goal} - {r_alf_now[31], r_alf_now};
    assign ofs_diff_abs = abs33(ofs_diff);
    assign alf_diff_abs = abs33(alf_diff);
    assign ofs_vel_abs  = abs33({r_ofs_vel[31], r_ofs_vel});
    assign alf_vel_abs  = abs33({r_alf_vel[31], r_alf_vel});
    assign ofs_active   = (ofs_diff_abs > 33'(TENTH)) || (ofs_vel_abs > 33'(TENTH));
    assign alf_active   = (alf_diff_abs > 33'(TENTH)) || (alf_vel_abs > 33'(TENTH));

    // Front-end decision terms, valid on the accept cycle.
    logic signed [16:0] dx, dy;
    logic [16:0]        adx, ady;
    logic               moving;
    logic [31:0]        still_ms;
    logic [DT_W-1:0]    dt_lim;

    assign dx       = {i_cursor_x[15], i_cursor_x} - {r_prev_x[15], r_prev_x};
    assign dy       = {i_cursor_y[15], i_cursor_y} - {r_prev_y[15], r_prev_y};
    assign adx      = dx[16] ? 17'(-dx) : 17'(dx);
    assign ady      = dy[16] ? 17'(-dy) : 17'(dy);
    assign moving   = (adx > {9'd0, r_move_thr}) || (ady > {9'd0, r_move_thr});
    assign still_ms = i_time_ms - r_active_since;
    assign dt_lim   = (i_elapsed_q16 > DT_LIMIT) ? DT_SUBST : i_elapsed_q16[DT_W-1:0];

    // Product-derived terms for the motion steps.
    logic signed [31:0] vel_acc_ofs, vel_acc_alf;
    logic signed [31:0] pos_up_ofs, pos_up_alf;
    logic signed [31:0] pos_dn_ofs, pos_dn_alf;
    logic               prod_big;

    assign vel_acc_ofs = sat32(t_prod'(r_ofs_vel) + (prod >>> ACC_SH));
    assign vel_acc_alf = sat32(t_prod'(r_alf_vel) + (prod >>> ACC_SH));
    assign pos_up_ofs  = sat32(t_prod'(r_ofs_now) + (prod >>> DT_SH));
    assign pos_up_alf  = sat32(t_prod'(r_alf_now) - (prod >>> DT_SH));
    assign pos_dn_ofs  = sat32(t_prod'(r_ofs_now) + (prod >>> DT_SH));
    assign pos_dn_alf  = sat32(t_prod'(r_alf_now) + (prod >>> DT_SH));
    // Gain times dt at or above one: the proportional step overshoots.
    assign prod_big    = prod[MUL_P_W-1:DT_SH] != '0;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);

    always_comb begin
        n_state        = r_state;
        n_ofs_now      = r_ofs_now;
        n_ofs_goal     = r_ofs_goal;
        n_ofs_vel      = r_ofs_vel;
        n_alf_now      = r_alf_now;
        n_alf_goal     = r_alf_goal;
        n_alf_vel      = r_alf_vel;
        n_last_ofs     = r_last_ofs;
        n_last_alf     = r_last_alf;
        n_prev_x       = r_prev_x;
        n_prev_y       = r_prev_y;
        n_active_since = r_active_since;
        n_hidden       = r_hidden;
        n_dt           = r_dt;
        n_settled      = r_settled;
        n_clamp        = r_clamp;
        n_out_valid    = r_out_valid && !i_out_ready;
        n_out_ofs      = r_out_ofs;
        n_out_alf      = r_out_alf;
        n_out_ofs_chg  = r_out_ofs_chg;
        n_out_alf_chg  = r_out_alf_chg;
        n_out_hidden   = r_out_hidden;
        n_out_settled  = r_out_settled;
        mul_req        = '{start: 1'b0, a: '0, b: '0};

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    // Select shown or hidden, then store the cursor.
                    if (moving) begin
                        if (i_on_desktop) begin
                            n_active_since = i_time_ms;
                            n_ofs_goal     = '0;
                            n_alf_goal     = ALPHA_FULL;
                            n_hidden       = 1'b0;
                        end
                    end else if (!r_hidden && (still_ms > r_hide_delay)) begin
                        n_ofs_goal = 32'(r_screen_h) << FRAC_BITS;
                        n_alf_goal = '0;
                        n_hidden   = 1'b1;
                        n_ofs_vel  = '0;
                        n_alf_vel  = '0;
                    end
                    n_prev_x = i_cursor_x;
                    n_prev_y = i_cursor_y;
                    n_dt     = dt_lim;
                    n_state  = S_SETTLE;
                end
            end
            S_SETTLE: begin
                // Both motions at rest: run the step with zero time.
                n_settled = (ofs_diff_abs < 33'(HALF)) && (ofs_vel_abs < 33'(ONE)) &&
                            (alf_diff_abs < 33'(HALF)) && (alf_vel_abs < 33'(ONE));
                if (n_settled) begin
                    n_dt = '0;
                end
                n_state = S_OFS;
            end
            S_OFS: begin
                if (!ofs_active) begin
                    n_ofs_now = r_ofs_goal;
                    n_state   = S_ALF;
                end else if (r_ofs_goal > r_ofs_now) begin
                    mul_req = '{start: 1'b1, a: MUL_A_W'(r_pos_accel), b: MUL_B_W'(r_dt)};
                    n_state = S_OUP1;
                end else begin
                    mul_req = '{start: 1'b1, a: MUL_A_W'(ofs_diff), b: MUL_B_W'(r_pos_speed)};
                    n_state = S_ODN1;
                end
            end
            S_OUP1: begin
                n_ofs_vel = vel_acc_ofs;
                n_state   = S_OUP2;
            end
            S_OUP2: begin
                mul_req = '{start: 1'b1, a: MUL_A_W'(r_ofs_vel), b: MUL_B_W'(r_dt)};
                n_state = S_OUP3;
            end
            S_OUP3: begin
                if (pos_up_ofs > r_ofs_goal) begin
                    n_ofs_now = r_ofs_goal;
                    n_ofs_vel = '0;
                end else begin
                    n_ofs_now = pos_up_ofs;
                end
                n_state = S_ALF;
            end
            S_ODN1: begin
                // Speed slower than the floor: use the floor speed.
                n_clamp = prod > t_prod'(OFS_MIN_SPD);
                mul_req = '{start: 1'b1, a: MUL_A_W'(r_pos_speed), b: MUL_B_W'(r_dt)};
                n_state = S_ODN2;
            end
            S_ODN2: begin
                if (r_clamp) begin
                    mul_req = '{start: 1'b1, a: OFS_MIN_SPD, b: MUL_B_W'(r_dt)};
                    n_state = S_ODN3;
                end else if (prod_big) begin
                    n_ofs_now = r_ofs_goal;
                    n_state   = S_ALF;
                end else begin
                    mul_req = '{start: 1'b1, a: MUL_A_W'(ofs_diff),
                                b: {1'b0, prod[DT_SH-1:0]}};
                    n_state = S_ODN3;
                end
            end
            S_ODN3: begin
                n_ofs_now = (pos_dn_ofs < r_ofs_goal) ? r_ofs_goal : pos_dn_ofs;
                n_state   = S_ALF;
            end
            S_ALF: begin
                if (!alf_active) begin
                    n_alf_now = r_alf_goal;
                    n_state   = S_OUT;
                end else if (r_alf_goal < r_alf_now) begin
                    mul_req = '{start: 1'b1, a: MUL_A_W'(r_alpha_accel), b: MUL_B_W'(r_dt)};
                    n_state = S_AUP1;
                end else begin
                    mul_req = '{start: 1'b1, a: MUL_A_W'(alf_diff),
                                b: MUL_B_W'(r_alpha_speed)};
                    n_state = S_ADN1;
                end
            end
            S_AUP1: begin
                n_alf_vel = vel_acc_alf;
                n_state   = S_AUP2;
            end
            S_AUP2: begin
                mul_req = '{start: 1'b1, a: MUL_A_W'(r_alf_vel), b: MUL_B_W'(r_dt)};
                n_state = S_AUP3;
            end
            S_AUP3: begin
                if (pos_up_alf < r_alf_goal) begin
                    n_alf_now = r_alf_goal;
                    n_alf_vel = '0;
                end else begin
                    n_alf_now = pos_up_alf;
                end
                n_state = S_OUT;
            end
            S_ADN1: begin
                n_clamp = prod < t_prod'(ALF_MIN_SPD);
                mul_req = '{start: 1'b1, a: MUL_A_W'(r_alpha_speed), b: MUL_B_W'(r_dt)};
                n_state = S_ADN2;
            end
            S_ADN2: begin
                if (r_clamp) begin
                    mul_req = '{start: 1'b1, a: ALF_MIN_SPD, b: MUL_B_W'(r_dt)};
                    n_state = S_ADN3;
                end else if (prod_big) begin
                    n_alf_now = r_alf_goal;
                    n_state   = S_OUT;
                end else begin
                    mul_req = '{start: 1'b1, a: MUL_A_W'(alf_diff),
                                b: {1'b0, prod[DT_SH-1:0]}};
                    n_state = S_ADN3;
                end
            end
            S_ADN3: begin
                n_alf_now = (pos_dn_alf > r_alf_goal) ? r_alf_goal : pos_dn_alf;
                n_state   = S_OUT;
            end
            S_OUT: begin
                // Hold until the previous result has left the output register.
                if (!r_out_valid || i_out_ready) begin
                    n_out_ofs     = whole_lim(r_ofs_now, 13'd8191);
                    n_out_alf     = 8'(whole_lim(r_alf_now, 13'd255));
                    n_out_ofs_chg = n_out_ofs != r_last_ofs;
                    n_out_alf_chg = n_out_alf != r_last_alf;
                    n_out_hidden  = r_hidden;
                    n_out_settled = r_settled;
                    n_out_valid   = 1'b1;
                    n_last_ofs    = n_out_ofs;
                    n_last_alf    = n_out_alf;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hide_delay   <= 32'd5000;
            r_pos_speed    <= 8'd0;
            r_pos_accel    <= 16'd0;
            r_alpha_speed  <= 8'd16;
            r_alpha_accel  <= 16'd128;
            r_screen_h     <= 13'd1080;
            r_move_thr     <= 8'd2;
            r_state        <= S_IDLE;
            r_ofs_now      <= '0;
            r_ofs_goal     <= '0;
            r_ofs_vel      <= '0;
            r_alf_now      <= ALPHA_FULL;
            r_alf_goal     <= ALPHA_FULL;
            r_alf_vel      <= '0;
            r_last_ofs     <= '0;
            r_last_alf     <= 8'd255;
            r_prev_x       <= '0;
            r_prev_y       <= '0;
            r_active_since <= '0;
            r_hidden       <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_HIDE_DELAY:  r_hide_delay  <= i_cfg_data;
                    CFG_POS_SPEED:   r_pos_speed   <= i_cfg_data[7:0];
                    CFG_POS_ACCEL:   r_pos_accel   <= i_cfg_data[15:0];
                    CFG_ALPHA_SPEED: r_alpha_speed <= i_cfg_data[7:0];
                    CFG_ALPHA_ACCEL: r_alpha_accel <= i_cfg_data[15:0];
                    CFG_SCREEN_H:    r_screen_h    <= i_cfg_data[12:0];
                    CFG_MOVE_THR:    r_move_thr    <= i_cfg_data[7:0];
                    default: begin
                        // Drop writes beyond the register list.
                    end
                endcase
            end
            r_state        <= n_state;
            r_ofs_now      <= n_ofs_now;
            r_ofs_goal     <= n_ofs_goal;
            r_ofs_vel      <= n_ofs_vel;
            r_alf_now      <= n_alf_now;
            r_alf_goal     <= n_alf_goal;
            r_alf_vel      <= n_alf_vel;
            r_last_ofs     <= n_last_ofs;
            r_last_alf     <= n_last_alf;
            r_prev_x       <= n_prev_x;
            r_prev_y       <= n_prev_y;
            r_active_since <= n_active_since;
            r_hidden       <= n_hidden;
            r_out_valid    <= n_out_valid;
        end
    end

    // Working and payload registers: no reset needed.
    always_ff @(posedge i_clk) begin
        r_dt          <= n_dt;
        r_settled     <= n_settled;
        r_clamp       <= n_clamp;
        r_out_ofs     <= n_out_ofs;
        r_out_alf     <= n_out_alf;
        r_out_ofs_chg <= n_out_ofs_chg;
        r_out_alf_chg <= n_out_alf_chg;
        r_out_hidden  <= n_out_hidden;
        r_out_settled <= n_out_settled;
    end

    assign o_out_valid      = r_out_valid;
    assign o_render_offset  = r_out_ofs;
    assign o_render_alpha   = r_out_alf;
    assign o_offset_changed = r_out_ofs_chg;
    assign o_alpha_changed  = r_out_alf_chg;
    assign o_hidden         = r_out_hidden;
    assign o_settled        = r_out_settled;

    // Final step with a result still waiting in the output register.
    logic out_wait;
    assign out_wait = (r_state == S_OUT) && r_out_valid;

    // An accepted request always starts with the settle test.
    `ISFA_ASSERT_NXT(a_accept_settle, i_clk, i_rst_n, i_in_valid && o_in_ready, r_state == S_SETTLE)
    // A waiting result is never overwritten by the final step.
    `ISFA_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, out_wait && !i_out_ready, out_wait)
    // The hidden flag and the alpha goal always agree.
    `ISFA_ASSERT_IMP(a_hidden_goal, i_clk, i_rst_n, r_hidden, r_alf_goal == '0)
    `ISFA_ASSERT_IMP(a_shown_goal, i_clk, i_rst_n, !r_hidden, r_alf_goal == ALPHA_FULL)

endmodule
